### sv/pbd_pkg.sv
// pbd_pkg: shared constants, types and pixel arithmetic for the box downscaler.
// No dependencies; every other file but pbd_ram imports it.
`default_nettype none

package pbd_pkg;

	localparam int MAX_WIDTH   = 4096;
	localparam int MAX_LEVELS  = 12;
	localparam int DIM_W       = 13;
	localparam int PIX_W       = 32;
	localparam int LVL_W       = $clog2(MAX_LEVELS + 1);
	localparam int CFG_IDX_W   = 3;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

	// pixel formats
	localparam logic [2:0] FMT_RGBA8888 = 3'd0;
	localparam logic [2:0] FMT_RGB888   = 3'd1;
	localparam logic [2:0] FMT_RGB565   = 3'd2;
	localparam logic [2:0] FMT_LA88     = 3'd3;
	localparam logic [2:0] FMT_L8       = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = 3'd4;

	// settings handed from the front end to the level pipeline
	typedef struct packed {
		logic [2:0]       fmt;
		logic [LVL_W-1:0] levels;
		logic [DIM_W-1:0] src_w;
		logic [DIM_W-1:0] src_h;
		logic [DIM_W-1:0] res_w;
		logic [DIM_W-1:0] res_h;
		logic             restart;
	} cfg_t;

	// used bits of a pixel per format
	function automatic logic [PIX_W-1:0] fmt_mask(input logic [2:0] fmt);
		case (fmt)
			FMT_RGB888: fmt_mask = 32'h00FF_FFFF;
			FMT_RGB565, FMT_LA88: fmt_mask = 32'h0000_FFFF;
			FMT_L8: fmt_mask = 32'h0000_00FF;
			default: fmt_mask = 32'hFFFF_FFFF;
		endcase
	endfunction

	// truncating per-component average of two pixels
	function automatic logic [PIX_W-1:0] avg_pixel(input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b, input logic [2:0] fmt);
		logic [PIX_W-1:0] bytes;
		logic [4:0] r5;
		logic [5:0] g6;
		logic [4:0] b5;
		int k;
		for (k = 0; k < 4; k++) begin
			bytes[8*k +: 8] = 8'((9'(a[8*k +: 8]) + 9'(b[8*k +: 8])) >> 1);
		end
		r5 = 5'((6'(a[15:11]) + 6'(b[15:11])) >> 1);
		g6 = 6'((7'(a[10:5]) + 7'(b[10:5])) >> 1);
		b5 = 5'((6'(a[4:0]) + 6'(b[4:0])) >> 1);
		case (fmt)
			FMT_RGB565: avg_pixel = {16'b0, r5, g6, b5};
			FMT_RGB888: avg_pixel = bytes & 32'h00FF_FFFF;
			FMT_LA88: avg_pixel = bytes & 32'h0000_FFFF;
			FMT_L8: avg_pixel = bytes & 32'h0000_00FF;
			default: avg_pixel = bytes;
		endcase
	endfunction

endpackage

`default_nettype wire

### sv/pbd_ram.sv
// pbd_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
`default_nettype none

module pbd_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### sv/pbd_fifo.sv
// pbd_fifo: short request queue between the front end and the level pipeline.
// Depends on pbd_pkg.
`default_nettype none

module pbd_fifo import pbd_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [PIX_W-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic      [PIX_W-1:0] pop_data,
	output logic                  not_empty
);

	logic [PIX_W-1:0]   mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	assign full      = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

### sv/pbd_front.sv
// pbd_front: configuration registers, level count, and input request intake.
// Depends on pbd_pkg.
`default_nettype none

module pbd_front import pbd_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DIM_W-1:0]     cfg_data,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [PIX_W-1:0]     s_axis_tdata,
	output logic                      push,
	output logic      [PIX_W-1:0]     push_data,
	input  wire logic                 full,
	output cfg_t                      cfg
);

	logic [2:0]       fmt_q;
	logic [DIM_W-1:0] src_w_q, src_h_q, tgt_w_q, tgt_h_q;
	logic [LVL_W-1:0] levels_q;
	logic [MAX_LEVELS-1:0] lvl_ok;
	logic             valid_idx;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q   <= FMT_RGBA8888;
			src_w_q <= DIM_W'(1);
			src_h_q <= DIM_W'(1);
			tgt_w_q <= '0;
			tgt_h_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PIXEL_FORMAT: fmt_q <= cfg_data[2:0];
				REG_SOURCE_WIDTH: src_w_q <= cfg_data;
				REG_SOURCE_HEIGHT: src_h_q <= cfg_data;
				REG_TARGET_WIDTH: tgt_w_q <= cfg_data;
				REG_TARGET_HEIGHT: tgt_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// each halving step is allowed on its own; the conditions shrink monotonically
	always_comb begin
		int i;
		for (i = 1; i <= MAX_LEVELS; i++) begin
			lvl_ok[i-1] = ((src_w_q >> i) >= tgt_w_q) && ((src_h_q >> i) >= tgt_h_q) &&
				((src_w_q >> i) != '0) && ((src_h_q >> i) != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q <= '0;
		end else begin
			levels_q <= LVL_W'($countones(lvl_ok));
		end
	end

	assign valid_idx = (cfg_index <= REG_TARGET_HEIGHT);

	assign cfg.fmt     = fmt_q;
	assign cfg.levels  = levels_q;
	assign cfg.src_w   = src_w_q;
	assign cfg.src_h   = src_h_q;
	assign cfg.res_w   = src_w_q >> levels_q;
	assign cfg.res_h   = src_h_q >> levels_q;
	assign cfg.restart = cfg_we && valid_idx;

	// intake: mask unused bits and queue the request
	assign s_axis_tready = !full;
	assign push          = s_axis_tvalid && !full;
	assign push_data     = s_axis_tdata & fmt_mask(fmt_q);

endmodule

`default_nettype wire

### sv/pbd_back.sv
// pbd_back: level pipeline, two stages per halving level with one row RAM each,
// plus the output register. Depends on pbd_pkg and pbd_ram.
`default_nettype none

module pbd_back import pbd_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cfg_t             cfg,
	input  wire logic             fifo_valid,
	input  wire logic [PIX_W-1:0] fifo_data,
	output logic                  pop,
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	output logic      [63:0]      m_axis_tdata,
	output logic                  m_axis_tlast
);

	wire                  lv_v  [0:MAX_LEVELS];
	wire [PIX_W-1:0]      lv_p  [0:MAX_LEVELS];
	wire [DIM_W-1:0]      lv_ox [0:MAX_LEVELS];
	wire [DIM_W-1:0]      lv_oy [0:MAX_LEVELS];

	logic             en;
	logic             out_v_q;
	logic [PIX_W-1:0] out_p_q;
	logic [DIM_W-1:0] out_w_q, out_h_q;
	logic             out_last_q;
	logic             last_nx;

	// whole pipeline advances while the output register can take a result
	assign en  = !out_v_q || m_axis_tready;
	assign pop = en && fifo_valid;

	assign lv_v[0]  = fifo_valid;
	assign lv_p[0]  = fifo_data;
	assign lv_ox[0] = '0;
	assign lv_oy[0] = '0;

	genvar i;
	generate
		for (i = 0; i < MAX_LEVELS; i++) begin : gen_lvl
			localparam int DEPTH = MAX_WIDTH >> (i + 1);
			localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

			logic [DIM_W-1:0] w, h, col_q, row_q, col_nx, row_nx, c1, r1;
			logic [DIM_W-2:0] k;
			logic             act, cnt, region, in_rng, wr;
			logic [PIX_W-1:0] pend_q, hv, rd;
			logic             a_v_s1, a_rd_s1, a_in_s1;
			logic [PIX_W-1:0] a_hv_s1;
			logic [DIM_W-1:0] a_ox_s1, a_oy_s1;
			logic             b_v_s2;
			logic [PIX_W-1:0] b_p_s2;
			logic [DIM_W-1:0] b_ox_s2, b_oy_s2;

			assign w      = cfg.src_w >> i;
			assign h      = cfg.src_h >> i;
			assign act    = (LVL_W'(i) < cfg.levels);
			// level 0 keeps counting in pass-through so positions are known
			assign cnt    = act || ((i == 0) && (cfg.levels == '0));
			assign region = (col_q < {w[DIM_W-1:1], 1'b0}) && (row_q < {h[DIM_W-1:1], 1'b0});
			assign k      = col_q[DIM_W-1:1];
			assign in_rng = (k < (DIM_W-1)'(DEPTH));
			assign hv     = avg_pixel(pend_q, lv_p[i], cfg.fmt);

			// raster position step
			always_comb begin
				c1     = col_q + 1'b1;
				r1     = row_q + 1'b1;
				col_nx = c1;
				row_nx = row_q;
				if (c1 >= w) begin
					col_nx = '0;
					row_nx = (r1 >= h) ? '0 : r1;
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					col_q <= '0;
					row_q <= '0;
				end else if (cfg.restart) begin
					col_q <= '0;
					row_q <= '0;
				end else if (en && lv_v[i] && cnt) begin
					col_q <= col_nx;
					row_q <= row_nx;
				end
			end

			// left pixel of the current pair
			always_ff @(posedge clk) begin
				if (en && lv_v[i] && act && region && !col_q[0]) begin
					pend_q <= lv_p[i];
				end
			end

			// halved even row goes to the row RAM
			assign wr = en && lv_v[i] && act && region && col_q[0] && !row_q[0] && in_rng;

			pbd_ram #(
				.DEPTH(DEPTH),
				.WIDTH(PIX_W),
				.AW   (AW)
			) u_ram (
				.clk  (clk),
				.we   (wr),
				.waddr(k[AW-1:0]),
				.wdata(hv),
				.re   (en),
				.raddr(k[AW-1:0]),
				.rdata(rd)
			);

			// stage 1: horizontal average and row read
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					a_v_s1 <= 1'b0;
				end else if (en) begin
					a_v_s1 <= lv_v[i] && (!act || (region && col_q[0] && row_q[0]));
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					a_rd_s1 <= act;
					a_in_s1 <= in_rng;
					a_hv_s1 <= act ? hv : lv_p[i];
					a_ox_s1 <= act ? {1'b0, k} : (cnt ? col_q : lv_ox[i]);
					a_oy_s1 <= act ? {1'b0, row_q[DIM_W-1:1]} : (cnt ? row_q : lv_oy[i]);
				end
			end

			// stage 2: vertical average with the stored row
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					b_v_s2 <= 1'b0;
				end else if (en) begin
					b_v_s2 <= a_v_s1;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					b_p_s2  <= a_rd_s1 ? avg_pixel(a_in_s1 ? rd : '0, a_hv_s1, cfg.fmt)
						: a_hv_s1;
					b_ox_s2 <= a_ox_s1;
					b_oy_s2 <= a_oy_s1;
				end
			end

			assign lv_v[i+1]  = b_v_s2;
			assign lv_p[i+1]  = b_p_s2;
			assign lv_ox[i+1] = b_ox_s2;
			assign lv_oy[i+1] = b_oy_s2;
		end
	endgenerate

	// final pixel of the output image
	assign last_nx = (cfg.res_w != '0) && (cfg.res_h != '0) &&
		(lv_ox[MAX_LEVELS] == cfg.res_w - 1'b1) && (lv_oy[MAX_LEVELS] == cfg.res_h - 1'b1);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= lv_v[MAX_LEVELS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_p_q    <= lv_p[MAX_LEVELS];
			out_w_q    <= cfg.res_w;
			out_h_q    <= cfg.res_h;
			out_last_q <= last_nx;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {6'b0, out_h_q, out_w_q, out_p_q};

`ifndef ASSERT_OFF
	a_lvl_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.levels <= LVL_W'(MAX_LEVELS))
		else $error("level count beyond maximum");

	a_hold_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(lv_v[MAX_LEVELS]) && $stable(lv_p[MAX_LEVELS]))
		else $error("pipeline moved while stalled");

	a_last_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_last_q |-> (out_w_q != '0) && (out_h_q != '0))
		else $error("frame end flagged with empty image");
`endif

endmodule

`default_nettype wire

### sv/pow2_box_downscaler.sv
// Box downscaler: takes one pixel per clock while its queue has room and
// returns one result pixel per clock at most. Each pixel passes the queue,
// the two pipeline stages of every halving level and the output register.
// Every level owns its own row RAM, so all levels work in parallel, and
// inactive levels just pass the pixel along. An output stall freezes the
// whole pipeline; the input stays ready until the four-entry queue fills.
// Row RAMs need no clearing pass after reset. Configuration must be written
// with the pipeline drained. The level count is registered from the size
// registers, so it settles after them.
// Depends on pbd_pkg, pbd_front, pbd_fifo, pbd_back.
`default_nettype none

module pow2_box_downscaler import pbd_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DIM_W-1:0]     cfg_data,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [31:0]          s_axis_tdata,   // pixel_in[31:0]
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output logic      [63:0]          m_axis_tdata,   // pixel_out[31:0], result_width[44:32],
	                                                  // result_height[57:45], zero fill
	output logic                      m_axis_tlast    // frame_last
);

	cfg_t             cfg;
	logic             push, full, pop, not_empty;
	logic [PIX_W-1:0] push_data, pop_data;

	pbd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.push         (push),
		.push_data    (push_data),
		.full         (full),
		.cfg          (cfg)
	);

	pbd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop      (pop),
		.pop_data (pop_data),
		.not_empty(not_empty)
	);

	pbd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.fifo_valid   (not_empty),
		.fifo_data    (pop_data),
		.pop          (pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule

`default_nettype wire

### tb/tb_top.sv
// tb_top: self-checking testbench for pow2_box_downscaler (2x2 box-filter downscale).
// Holds its own pixel/level predictor, drives random stream gaps and stalls.
// Depends on pbd_pkg and the pow2_box_downscaler RTL.
`timescale 1ns / 100ps

module tb_top;
	import pbd_pkg::*;

	localparam int         CYCLE_LIMIT = 600000;
	localparam int         DRAIN_CYCLES = 80;
	localparam logic [2:0] REG_UNUSED = 3'd7;

	typedef struct {
		logic [31:0] pixel;
		logic [12:0] width;
		logic [12:0] height;
		logic        last;
	} scaled_px_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0]     cfg_data;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [31:0]          s_axis_tdata;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [63:0]          m_axis_tdata;
	logic                 m_axis_tlast;

	// predictor state
	logic [2:0]  fmt_q;
	logic [12:0] src_w_q, src_h_q, tgt_w_q, tgt_h_q;
	logic [31:0] half_rows [0:MAX_WIDTH-1];
	logic [31:0] left_px [0:MAX_LEVELS-1];
	int          lvl_col [0:MAX_LEVELS-1];
	int          lvl_row [0:MAX_LEVELS-1];

	scaled_px_t  pending_px[$];
	int          errors;
	int          cycles;
	bit          busy_sender;
	int          sent_px;

	pow2_box_downscaler i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	// used bits of a pixel
	function automatic logic [31:0] used_bits(input logic [2:0] f);
		case (f)
			FMT_RGB888: return 32'h00FF_FFFF;
			FMT_RGB565, FMT_LA88: return 32'h0000_FFFF;
			FMT_L8: return 32'h0000_00FF;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	// truncating mean per component
	function automatic logic [31:0] mean_px(input logic [31:0] a, input logic [31:0] b,
		input logic [2:0] f);
		logic [31:0] acc;
		int          n;
		acc = '0;
		if (f == FMT_RGB565) begin
			acc[15:11] = 5'((a[15:11] + 6'(b[15:11])) >> 1);
			acc[10:5]  = 6'((a[10:5] + 7'(b[10:5])) >> 1);
			acc[4:0]   = 5'((a[4:0] + 6'(b[4:0])) >> 1);
			return acc;
		end
		case (f)
			FMT_RGB888: n = 3;
			FMT_LA88: n = 2;
			FMT_L8: n = 1;
			default: n = 4;
		endcase
		for (int k = 0; k < n; k++)
			acc[8*k +: 8] = 8'((a[8*k +: 8] + 9'(b[8*k +: 8])) >> 1);
		return acc;
	endfunction

	task automatic restart_position();
		for (int i = 0; i < MAX_LEVELS; i++) begin
			lvl_col[i] = 0;
			lvl_row[i] = 0;
		end
	endtask

	// advance level 0 by one source pixel and each higher level by the pixel below it, queue the result if any
	task automatic scale_pixel(input logic [31:0] din);
		int          wd [0:MAX_LEVELS];
		int          ht [0:MAX_LEVELS];
		int          lv, c, r, k, idx, ox, oy;
		logic [31:0] p, hv, above;
		bit          have, frame_end, produced;
		scaled_px_t  e;
		lv = 0;
		wd[0] = src_w_q;
		ht[0] = src_h_q;
		while (lv < MAX_LEVELS && (wd[lv] >> 1) >= tgt_w_q && (ht[lv] >> 1) >= tgt_h_q &&
				(wd[lv] >> 1) >= 1 && (ht[lv] >> 1) >= 1) begin
			wd[lv+1] = wd[lv] >> 1;
			ht[lv+1] = ht[lv] >> 1;
			lv++;
		end
		p = din & used_bits(fmt_q);
		have = 1;
		frame_end = 0;
		ox = lvl_col[0];
		oy = lvl_row[0];
		for (int i = 0; i < lv || i == 0; i++) begin
			c = lvl_col[i];
			r = lvl_row[i];
			produced = 0;
			if (i < lv && c < (wd[i] & ~1) && r < (ht[i] & ~1)) begin
				if (c % 2 == 0) begin
					left_px[i] = p;
				end else begin
					hv = mean_px(left_px[i], p, fmt_q);
					k = c >> 1;
					idx = MAX_WIDTH - (MAX_WIDTH >> i) + k;
					if (r % 2 == 0) begin
						if (k < (MAX_WIDTH >> (i + 1))) half_rows[idx] = hv;
					end else begin
						above = (k < (MAX_WIDTH >> (i + 1))) ? half_rows[idx] : '0;
						p = mean_px(above, hv, fmt_q);
						ox = k;
						oy = r >> 1;
						produced = 1;
					end
				end
			end
			c++;
			if (c >= wd[i]) begin
				c = 0;
				r++;
				if (r >= ht[i]) begin
					r = 0;
					if (i == 0) frame_end = 1;
				end
			end
			lvl_col[i] = c;
			lvl_row[i] = r;
			if (i < lv && !produced) begin
				have = 0;
				break;
			end
			if (lv == 0) break;
		end
		if (have) begin
			e.pixel = p;
			e.width = 13'(wd[lv]);
			e.height = 13'(ht[lv]);
			e.last = (ox == wd[lv] - 1 && oy == ht[lv] - 1);
			pending_px.push_back(e);
		end
		if (frame_end) restart_position();
	endtask

	// register write, block idle; starts and ends at a falling edge
	task automatic write_reg(input logic [2:0] idx, input int val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 13'(val);
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_PIXEL_FORMAT: fmt_q = 3'(val);
			REG_SOURCE_WIDTH: src_w_q = 13'(val);
			REG_SOURCE_HEIGHT: src_h_q = 13'(val);
			REG_TARGET_WIDTH: tgt_w_q = 13'(val);
			REG_TARGET_HEIGHT: tgt_h_q = 13'(val);
			default: ;
		endcase
		if (idx <= REG_TARGET_HEIGHT) restart_position();
	endtask

	task automatic wait_idle();
		while (pending_px.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_frame(input int f, input int sw, input int sh, input int tw, input int th);
		wait_idle();
		write_reg(REG_PIXEL_FORMAT, f);
		write_reg(REG_SOURCE_WIDTH, sw);
		write_reg(REG_SOURCE_HEIGHT, sh);
		write_reg(REG_TARGET_WIDTH, tw);
		write_reg(REG_TARGET_HEIGHT, th);
	endtask

	// one request on the input stream; starts and ends at a falling edge
	task automatic send_pixel(input logic [31:0] px);
		int gap, roll;
		roll = $urandom_range(0, 99);
		gap = 0;
		if (busy_sender) begin
			if (roll >= 55) gap = (roll < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
		end
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= px;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		scale_pixel(px);
		sent_px++;
		@(negedge clk);
	endtask

	task automatic stop_sending();
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic send_frame(input int sw, input int sh);
		for (int n = 0; n < sw * sh; n++) send_pixel($urandom);
		stop_sending();
	endtask

	// 1x1 source: no levels, every format code incl. unused ones, extreme pixels
	task automatic test_pass_through();
		for (int f = 0; f < 8; f++) begin
			set_frame(f, 1, 1, 0, 0);
			send_pixel(32'hFFFF_FFFF);
			send_pixel(32'h0000_0000);
			stop_sending();
		end
		// target larger than source keeps full size
		set_frame(FMT_RGBA8888, 3, 2, 4096, 4096);
		send_frame(3, 2);
	endtask

	// one 2x2 box per format with saturated and mixed components
	task automatic test_formats();
		for (int f = 0; f <= FMT_L8; f++) begin
			set_frame(f, 2, 2, 1, 1);
			send_pixel(32'hFFFF_FFFF);
			send_pixel(32'hFFFF_FFFF);
			send_pixel(32'hFFFF_FFFF);
			send_pixel(32'h0000_0000);
			stop_sending();
		end
		// unused register index must not disturb the frame
		wait_idle();
		write_reg(REG_UNUSED, 13'h1FFF);
	endtask

	// odd edges dropped, then a wide line pair, a tall frame cut short and a 16x16 frame
	task automatic test_odd_and_wide();
		set_frame(FMT_RGB565, 5, 3, 0, 0);
		send_frame(5, 3);
		set_frame(FMT_L8, 256, 2, 0, 0);
		send_frame(256, 2);
		set_frame(FMT_LA88, 2, 4096, 2, 0);
		send_frame(2, 4);
		set_frame(FMT_RGB888, 16, 16, 0, 0);
		send_frame(16, 16);
	endtask

	// random sizes, targets and formats; a few frames cut short
	task automatic test_random_frames();
		int sw, sh, tw, th, n;
		while (sent_px < 1200) begin
			sw = $urandom_range(1, 20);
			sh = $urandom_range(1, 20);
			tw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, sw) : 0;
			th = ($urandom_range(0, 3) == 0) ? $urandom_range(0, sh) : 0;
			set_frame($urandom_range(0, 7), sw, sh, tw, th);
			busy_sender = ($urandom_range(0, 3) != 0);
			n = sw * sh * $urandom_range(1, 3);
			if ($urandom_range(0, 7) == 0) n = $urandom_range(1, sw * sh);
			for (int i = 0; i < n; i++) send_pixel($urandom);
			stop_sending();
		end
		busy_sender = 1;
	endtask

	// output-side backpressure
	int stall_left;
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(0, 99) < 25) begin
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// result checker
	always @(posedge clk) begin
		scaled_px_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_px.size() == 0) begin
				$display("%0t: unexpected result %h last %b", $realtime, m_axis_tdata,
					m_axis_tlast);
				errors++;
			end else begin
				e = pending_px.pop_front();
				if (m_axis_tdata[31:0] !== e.pixel) begin
					$display("%0t: pixel exp %h got %h", $realtime, e.pixel,
						m_axis_tdata[31:0]);
					errors++;
				end
				if (m_axis_tdata[44:32] !== e.width) begin
					$display("%0t: width exp %0d got %0d", $realtime, e.width,
						m_axis_tdata[44:32]);
					errors++;
				end
				if (m_axis_tdata[57:45] !== e.height) begin
					$display("%0t: height exp %0d got %0d", $realtime, e.height,
						m_axis_tdata[57:45]);
					errors++;
				end
				if (m_axis_tdata[63:58] !== 6'b0) begin
					$display("%0t: fill exp 0 got %h", $realtime, m_axis_tdata[63:58]);
					errors++;
				end
				if (m_axis_tlast !== e.last) begin
					$display("%0t: last exp %b got %b", $realtime, e.last, m_axis_tlast);
					errors++;
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		stall_left = 0;
		errors = 0;
		cycles = 0;
		sent_px = 0;
		busy_sender = 1;
		fmt_q = FMT_RGBA8888;
		src_w_q = 1;
		src_h_q = 1;
		tgt_w_q = 0;
		tgt_h_q = 0;
		restart_position();
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_pass_through();
		test_formats();
		test_odd_and_wide();
		test_random_frames();

		wait_idle();
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
